// ----- hdl/dqp_pkg.sv -----
// Package for the DNS question parser: parse phases, result kinds,
// queue entry types and shared constants. No dependencies.
`default_nettype none

package dqp_pkg;

  // Message layout.
  localparam int unsigned HeaderBytes = 12;
  localparam int unsigned HeaderWords = 6;
  localparam int unsigned QCountWord  = 2;
  localparam int unsigned TailBytes   = 4;
  localparam logic [7:0]  DotChar     = 8'h2E;
  localparam logic [7:0]  NameLengthLimit = 8'd255;

  // Queue between the parser and the result sequencer.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LABEL_LEN,
    PH_LABEL_BODY,
    PH_TAIL,
    PH_IGNORE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_CHAR,
    KIND_DONE,
    KIND_STATUS
  } result_kind_e;

  // One queue entry: the results caused by one input beat.
  typedef struct packed {
    logic         has_main;
    result_kind_e kind;
    logic [15:0]  message_id;
    logic [15:0]  header_flags;
    logic [15:0]  question_count;
    logic [15:0]  answer_count;
    logic [15:0]  authority_count;
    logic [15:0]  additional_count;
    logic [7:0]   name_char;
    logic [15:0]  query_type;
    logic [7:0]   name_length;
    logic         has_status;
    logic         malformed;
  } dqp_entry_t;

  // Head of the queue as seen by the result sequencer.
  typedef struct packed {
    logic       valid;
    dqp_entry_t entry;
  } dqp_head_t;

endpackage

`default_nettype wire

// ----- hdl/dqp_if.sv -----
// Handshake interfaces for the DNS question parser input and result channels.
// No dependencies.
`default_nettype none

interface dqp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       end_of_packet;

  modport source (output valid, packet_byte, end_of_packet, input ready);
  modport sink   (input valid, packet_byte, end_of_packet, output ready);
endinterface

interface dqp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] message_id;
  logic [15:0] header_flags;
  logic [15:0] question_count;
  logic [15:0] answer_count;
  logic [15:0] authority_count;
  logic [15:0] additional_count;
  logic [7:0]  name_char;
  logic [15:0] query_type;
  logic [7:0]  name_length;
  logic        malformed;
  logic        last_result;

  modport source (output valid, result_kind, message_id, header_flags, question_count,
                  answer_count, authority_count, additional_count, name_char,
                  query_type, name_length, malformed, last_result, input ready);
  modport sink   (input valid, result_kind, message_id, header_flags, question_count,
                  answer_count, authority_count, additional_count, name_char,
                  query_type, name_length, malformed, last_result, output ready);
endinterface

`default_nettype wire

// ----- hdl/dqp_front.sv -----
// Parser front end: accepts message beats, tracks header and question state,
// and pushes one queue entry per beat that causes results. Uses dqp_pkg, dqp_if.
`default_nettype none

module dqp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  dqp_in_if.sink             in_i,
  input  logic               q_full_i,
  output logic               push_o,
  output dqp_pkg::dqp_entry_t entry_o
);
  import dqp_pkg::*;

  logic [3:0]  hdr_pos_q, hdr_pos_d;
  logic [15:0] hdr_q [HeaderWords];
  phase_e      phase_q, phase_d;
  logic [7:0]  label_left_q, label_left_d;
  logic [7:0]  name_len_q, name_len_d;
  logic        first_q, first_d;
  logic [2:0]  tail_pos_q, tail_pos_d;
  logic [15:0] type_q, type_d;
  logic [15:0] qdone_q, qdone_d;

  logic        accept;
  logic [7:0]  pkt_byte;
  logic        eop;
  dqp_entry_t  ent;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign pkt_byte   = in_i.packet_byte;
  assign eop        = in_i.end_of_packet;

  // Header words fill big-endian, two beats per word.
  always_ff @(posedge clk_i) begin
    if (accept && (phase_q == PH_HEADER)) begin
      if (!hdr_pos_q[0]) begin
        hdr_q[hdr_pos_q[3:1]] <= {pkt_byte, 8'h00};
      end else begin
        hdr_q[hdr_pos_q[3:1]][7:0] <= pkt_byte;
      end
    end
  end

  // Parse state update and result classification.
  always_comb begin
    hdr_pos_d    = hdr_pos_q;
    phase_d      = phase_q;
    label_left_d = label_left_q;
    name_len_d   = name_len_q;
    first_d      = first_q;
    tail_pos_d   = tail_pos_q;
    type_d       = type_q;
    qdone_d      = qdone_q;
    ent          = '0;
    ent.kind     = KIND_HEADER;

    if (accept) begin
      unique case (phase_q)
        PH_HEADER: begin
          hdr_pos_d = hdr_pos_q + 4'd1;
          if (hdr_pos_q == 4'(HeaderBytes - 1)) begin
            ent.has_main         = 1'b1;
            ent.kind             = KIND_HEADER;
            ent.message_id       = hdr_q[0];
            ent.header_flags     = hdr_q[1];
            ent.question_count   = hdr_q[2];
            ent.answer_count     = hdr_q[3];
            ent.authority_count  = hdr_q[4];
            ent.additional_count = {hdr_q[5][15:8], pkt_byte};
            if (hdr_q[QCountWord] != 16'd0) begin
              phase_d      = PH_LABEL_LEN;
              first_d      = 1'b1;
              name_len_d   = 8'd0;
              label_left_d = 8'd0;
              tail_pos_d   = 3'd0;
            end else begin
              phase_d = PH_IGNORE;
            end
          end
        end
        PH_LABEL_LEN: begin
          if (pkt_byte == 8'd0) begin
            phase_d    = PH_TAIL;
            tail_pos_d = 3'd0;
          end else begin
            // Every label but the first is preceded by a dot.
            if (!first_q) begin
              ent.has_main  = 1'b1;
              ent.kind      = KIND_CHAR;
              ent.name_char = DotChar;
              if (name_len_q < NameLengthLimit) begin
                name_len_d = name_len_q + 8'd1;
              end
            end
            first_d      = 1'b0;
            label_left_d = pkt_byte;
            phase_d      = PH_LABEL_BODY;
          end
        end
        PH_LABEL_BODY: begin
          ent.has_main  = 1'b1;
          ent.kind      = KIND_CHAR;
          ent.name_char = pkt_byte;
          if (name_len_q < NameLengthLimit) begin
            name_len_d = name_len_q + 8'd1;
          end
          if (label_left_q > 8'd0) begin
            label_left_d = label_left_q - 8'd1;
          end
          if (label_left_d == 8'd0) begin
            phase_d = PH_LABEL_LEN;
          end
        end
        PH_TAIL: begin
          if (tail_pos_q == 3'd0) begin
            type_d = {pkt_byte, 8'h00};
          end else if (tail_pos_q == 3'd1) begin
            type_d = {type_q[15:8], pkt_byte};
          end
          tail_pos_d = tail_pos_q + 3'd1;
          if (tail_pos_q == 3'(TailBytes - 1)) begin
            ent.has_main    = 1'b1;
            ent.kind        = KIND_DONE;
            ent.query_type  = type_q;
            ent.name_length = name_len_q;
            qdone_d         = qdone_q + 16'd1;
            if (qdone_d >= hdr_q[QCountWord]) begin
              phase_d = PH_IGNORE;
            end else begin
              phase_d      = PH_LABEL_LEN;
              first_d      = 1'b1;
              name_len_d   = 8'd0;
              label_left_d = 8'd0;
              tail_pos_d   = 3'd0;
            end
          end
        end
        PH_IGNORE: begin
        end
        default: begin
        end
      endcase

      // The final beat reports status and returns the parser to its start.
      if (eop) begin
        ent.has_status = 1'b1;
        ent.malformed  = (phase_d == PH_HEADER) || (qdone_d < hdr_q[QCountWord]);
        hdr_pos_d      = 4'd0;
        phase_d        = PH_HEADER;
        label_left_d   = 8'd0;
        name_len_d     = 8'd0;
        first_d        = 1'b1;
        tail_pos_d     = 3'd0;
        type_d         = 16'd0;
        qdone_d        = 16'd0;
      end
    end
  end

  assign push_o  = accept && (ent.has_main || ent.has_status);
  assign entry_o = ent;

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q    <= 4'd0;
      phase_q      <= PH_HEADER;
      label_left_q <= 8'd0;
      name_len_q   <= 8'd0;
      first_q      <= 1'b1;
      tail_pos_q   <= 3'd0;
      type_q       <= 16'd0;
      qdone_q      <= 16'd0;
    end else begin
      hdr_pos_q    <= hdr_pos_d;
      phase_q      <= phase_d;
      label_left_q <= label_left_d;
      name_len_q   <= name_len_d;
      first_q      <= first_d;
      tail_pos_q   <= tail_pos_d;
      type_q       <= type_d;
      qdone_q      <= qdone_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dqp_queue.sv -----
// Short entry queue between the parser and the result sequencer.
// Uses dqp_pkg.
`default_nettype none

module dqp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dqp_pkg::dqp_entry_t entry_i,
  input  logic                pop_i,
  output logic                full_o,
  output dqp_pkg::dqp_head_t  head_o
);
  import dqp_pkg::*;

  dqp_entry_t           mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q;

  assign full_o       = (count_q == (QueuePtrW + 1)'(QueueDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0
                                                             : wr_ptr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0
                                                             : rd_ptr_q + QueuePtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QueuePtrW + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QueuePtrW + 1)'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QueuePtrW + 1)'(QueueDepth))
    else $error("queue count above depth");

endmodule

`default_nettype wire

// ----- hdl/dqp_back.sv -----
// Result sequencer: expands each queue entry into one or two result beats
// and holds them in the output register. Uses dqp_pkg, dqp_if.
`default_nettype none

module dqp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dqp_pkg::dqp_head_t head_i,
  output logic               pop_o,
  dqp_out_if.source          out_o
);
  import dqp_pkg::*;

  typedef struct packed {
    result_kind_e kind;
    logic [15:0]  message_id;
    logic [15:0]  header_flags;
    logic [15:0]  question_count;
    logic [15:0]  answer_count;
    logic [15:0]  authority_count;
    logic [15:0]  additional_count;
    logic [7:0]   name_char;
    logic [15:0]  query_type;
    logic [7:0]   name_length;
    logic         malformed;
    logic         last;
  } beat_t;

  logic  out_valid_q, out_valid_d;
  logic  sub_q, sub_d;
  beat_t beat_q, beat_d;
  logic  load;
  logic  main_beat;

  assign load      = !out_valid_q || out_o.ready;
  assign main_beat = head_i.entry.has_main && !sub_q;

  // Pick the next beat: the main result first, then the packet status.
  always_comb begin
    beat_d      = '0;
    sub_d       = sub_q;
    out_valid_d = out_valid_q;
    pop_o       = 1'b0;
    if (main_beat) begin
      beat_d.kind             = head_i.entry.kind;
      beat_d.message_id       = head_i.entry.message_id;
      beat_d.header_flags     = head_i.entry.header_flags;
      beat_d.question_count   = head_i.entry.question_count;
      beat_d.answer_count     = head_i.entry.answer_count;
      beat_d.authority_count  = head_i.entry.authority_count;
      beat_d.additional_count = head_i.entry.additional_count;
      beat_d.name_char        = head_i.entry.name_char;
      beat_d.query_type       = head_i.entry.query_type;
      beat_d.name_length      = head_i.entry.name_length;
      beat_d.last             = !head_i.entry.has_status;
    end else begin
      beat_d.kind      = KIND_STATUS;
      beat_d.malformed = head_i.entry.malformed;
      beat_d.last      = 1'b1;
    end
    if (load) begin
      out_valid_d = head_i.valid;
      if (head_i.valid) begin
        sub_d = main_beat && head_i.entry.has_status;
        pop_o = !sub_d;
      end
    end
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sub_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sub_q       <= sub_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load && head_i.valid) begin
      beat_q <= beat_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.result_kind      = beat_q.kind;
  assign out_o.message_id       = beat_q.message_id;
  assign out_o.header_flags     = beat_q.header_flags;
  assign out_o.question_count   = beat_q.question_count;
  assign out_o.answer_count     = beat_q.answer_count;
  assign out_o.authority_count  = beat_q.authority_count;
  assign out_o.additional_count = beat_q.additional_count;
  assign out_o.name_char        = beat_q.name_char;
  assign out_o.query_type       = beat_q.query_type;
  assign out_o.name_length      = beat_q.name_length;
  assign out_o.malformed        = beat_q.malformed;
  assign out_o.last_result      = beat_q.last;

  a_sub_holds_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> (head_i.valid && head_i.entry.has_status))
    else $error("pending status beat without its queue entry");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (beat_q.kind == KIND_STATUS)) |-> beat_q.last)
    else $error("status beat not marked last");

  a_not_last_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !beat_q.last) |-> sub_q)
    else $error("non-last beat without pending status");

endmodule

`default_nettype wire

// ----- hdl/dns_question_parser.sv -----
// DNS header and question parser. A result passes from its accepted beat through
// the entry queue into the output register.
// Throughput: one message beat per cycle while the queue is not full; the final beat of a
// message that also completes a header or question yields two output beats, absorbed by a 4-entry queue.
// Reset: asynchronous, active low; clears parse state, queue and output valid at once.
// Uses dqp_pkg, dqp_if, dqp_front, dqp_queue, dqp_back.
`default_nettype none

module dns_question_parser (
  input  logic      clk_i,
  input  logic      rst_ni,
  dqp_in_if.sink    in_i,
  dqp_out_if.source out_o
);
  import dqp_pkg::*;

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  dqp_entry_t q_entry;
  dqp_head_t  q_head;

  // Parser front end.
  dqp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .entry_o  (q_entry)
  );

  // Decoupling queue.
  dqp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .head_o  (q_head)
  );

  // Result sequencer and output register.
  dqp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (q_head),
    .pop_o  (q_pop),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
